>>> rtl/core/sslc_pkg.sv
// shared constants and types for the lower-casing shell sort block
// no dependencies

package sslc_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ByteW = 8;

  // entry passed from the front end to the sort engine
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } sslc_item_t;

  // fold A-Z to a-z
  function automatic logic [ByteW-1:0] fold_lower(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

  // signed byte order as an unsigned key
  function automatic logic [ByteW-1:0] order_key(input logic [ByteW-1:0] b);
    return b ^ 8'h80;
  endfunction

endpackage

>>> rtl/core/sslc_front.sv
// front end: takes input transactions, folds case, queues them for the sort engine
// depends on sslc_pkg

module sslc_front
  import sslc_pkg::*;
#(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,
  input  logic       s_tlast_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output sslc_item_t q_item_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  sslc_item_t          mem_q [QDepth];
  logic [PtrW-1:0]     wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]       cnt_q, cnt_d;
  logic                push, pop;

  assign s_tready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(QDepth-1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrW'(QDepth-1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: fold_lower(s_tdata_i), last: s_tlast_i};
    end
  end

endmodule

>>> rtl/core/sslc_engine.sv
// back end: stores the string, shell-sorts it in memory, then streams it out
// depends on sslc_pkg

module sslc_engine
  import sslc_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  sslc_item_t q_item_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output logic       m_tlast_o,
  output logic       m_tuser_o
);

  localparam int unsigned AW = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned CW = $clog2(MaxLen + 1);

  typedef enum logic [3:0] {
    ST_LOAD, ST_GAP, ST_IRD, ST_IWAIT, ST_CRD, ST_CWAIT, ST_CMP, ST_PLACE,
    ST_ORD, ST_OWAIT, ST_OUT
  } state_e;

  state_e          state_q;
  logic [7:0]      mem_q [MaxLen];
  logic [7:0]      rdata_q;
  logic [AW-1:0]   raddr;
  logic            rd_en;
  logic            wr_en;
  logic [AW-1:0]   waddr;
  logic [7:0]      wdata;
  logic [CW-1:0]   cnt_q, gap_q, i_q, j_q, k_q;
  logic [7:0]      held_q;
  logic            ovf_q;
  logic            out_v_q, out_last_q;
  logic [7:0]      out_d_q;

  assign q_ready_o  = (state_q == ST_LOAD);
  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_d_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = ovf_q;

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    wr_en = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state_q)
      ST_LOAD: begin
        wr_en = q_valid_i && (cnt_q != CW'(MaxLen));
        waddr = cnt_q[AW-1:0];
        wdata = q_item_i.data;
      end
      ST_IRD: begin
        rd_en = 1'b1;
        raddr = i_q[AW-1:0];
      end
      ST_CRD: begin
        rd_en = 1'b1;
        raddr = AW'(j_q - gap_q);
      end
      ST_CMP: begin
        // shift the larger element up by one gap
        wr_en = (order_key(rdata_q) > order_key(held_q));
        waddr = j_q[AW-1:0];
        wdata = rdata_q;
      end
      ST_PLACE: begin
        wr_en = 1'b1;
        waddr = j_q[AW-1:0];
        wdata = held_q;
      end
      ST_ORD: begin
        rd_en = 1'b1;
        raddr = k_q[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      cnt_q      <= '0;
      gap_q      <= '0;
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      held_q     <= '0;
      ovf_q      <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_d_q    <= '0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (q_valid_i) begin
            if (cnt_q != CW'(MaxLen)) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (q_item_i.last) begin
              if (cnt_q != CW'(MaxLen)) begin
                gap_q <= CW'((cnt_q + 1'b1) >> 1);
              end else begin
                gap_q <= CW'(cnt_q >> 1);
              end
              state_q <= ST_GAP;
            end
          end
        end
        ST_GAP: begin
          if (gap_q == '0) begin
            k_q     <= '0;
            state_q <= ST_ORD;
          end else begin
            i_q     <= gap_q;
            state_q <= ST_IRD;
          end
        end
        ST_IRD: begin
          if (i_q >= cnt_q) begin
            gap_q   <= gap_q >> 1;
            state_q <= ST_GAP;
          end else begin
            j_q     <= i_q;
            state_q <= ST_IWAIT;
          end
        end
        ST_IWAIT: begin
          held_q  <= rdata_q;
          state_q <= ST_CRD;
        end
        ST_CRD: begin
          if (j_q < gap_q) begin
            state_q <= ST_PLACE;
          end else begin
            state_q <= ST_CWAIT;
          end
        end
        ST_CWAIT: state_q <= ST_CMP;
        ST_CMP: begin
          if (order_key(rdata_q) > order_key(held_q)) begin
            j_q     <= j_q - gap_q;
            state_q <= ST_CRD;
          end else begin
            state_q <= ST_PLACE;
          end
        end
        ST_PLACE: begin
          i_q     <= i_q + 1'b1;
          state_q <= ST_IRD;
        end
        ST_ORD: state_q <= ST_OWAIT;
        ST_OWAIT: begin
          out_v_q    <= 1'b1;
          out_d_q    <= rdata_q;
          out_last_q <= (k_q + 1'b1 == cnt_q);
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (m_tready_i) begin
            out_v_q <= 1'b0;
            if (out_last_q) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= ST_LOAD;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= ST_ORD;
            end
          end
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

endmodule

>>> rtl/core/shell_sort_lowercase_chars_top.sv
// after the final byte the store is sorted in place: each insertion step reads its element,
// then compares and shifts one gap down until it places it; about n*(log2(n)-1) steps in all
// then each byte is read out only after the sink took the one before (one read port on the store)
// loading takes one cycle per byte while the engine loads, through a two-entry queue
// reset is asynchronous, active low; count and truncation flag clear, the store does not
// depends on sslc_pkg, sslc_front, sslc_engine

module shell_sort_lowercase_chars_top
  import sslc_pkg::*;
#(
  parameter int unsigned MaxLen = MaxLenDefault,
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // byte_in
  input  logic       s_tlast_i,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // byte_out
  output logic       m_tlast_o,
  output logic       m_tuser_o    // truncated
);

  logic       q_valid, q_ready;
  sslc_item_t q_item;

  sslc_front #(.QDepth(QDepth)) u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tlast_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_item_o(q_item)
  );

  sslc_engine #(.MaxLen(MaxLen)) u_engine (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_item_i(q_item),
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tlast_o, .m_tuser_o
  );

endmodule

>>> rtl/core/sslc_checker.sv
// port-level checks for the shell sort top level
// bound onto shell_sort_lowercase_chars_top

module sslc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid_i,
  input logic       m_tready_i,
  input logic [7:0] m_tdata_i,
  input logic       m_tlast_i,
  input logic       m_tuser_i
);

  logic [7:0] prev_q;
  logic       mid_q;
  logic       user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= 1'b0;
      prev_q <= '0;
      user_q <= 1'b0;
    end else if (m_tvalid_i && m_tready_i) begin
      mid_q  <= !m_tlast_i;
      prev_q <= m_tdata_i;
      user_q <= m_tuser_i;
    end
  end

  // output is ascending in signed order within a string
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && mid_q) |-> ((prev_q ^ 8'h80) <= (m_tdata_i ^ 8'h80)))
    else $error("sorted output out of order");

  // no upper-case letters leave
  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> !(m_tdata_i >= 8'h41 && m_tdata_i <= 8'h5a))
    else $error("upper-case byte on output");

  // truncation flag constant within a string
  a_trunc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && mid_q) |-> (m_tuser_i == user_q))
    else $error("truncation flag changed within a string");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_i && !m_tready_i) |=> (m_tvalid_i && $stable(m_tdata_i) &&
      $stable(m_tlast_i) && $stable(m_tuser_i)))
    else $error("stalled output changed");

endmodule

bind shell_sort_lowercase_chars_top sslc_checker u_sslc_checker (
  .clk_i, .rst_ni, .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o),
  .m_tlast_i(m_tlast_o), .m_tuser_i(m_tuser_o)
);

>>> verif/tb_shell_sort_lowercase_chars_top.sv
// testbench for the lower-casing shell sort block: random strings in, sorted bytes checked out
// depends on sslc_pkg and shell_sort_lowercase_chars_top

module tb_shell_sort_lowercase_chars_top;
  import sslc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = MaxLenDefault;
  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       trunc;
  } sorted_char_t;

  int unsigned mismatch_cnt;

  task automatic report(input string what);
    $display("mismatch: %s", what);
    mismatch_cnt++;
  endtask

  class sort_scoreboard;
    logic [7:0]   held_chars[$];
    bit           dropped;
    sorted_char_t sorted_q[$];

    function void note_input(logic [7:0] b, logic is_last);
      logic [7:0] buf_c[$];
      logic [7:0] lc;
      logic [7:0] tmp;
      sorted_char_t e;
      int n, gap, i, j;
      lc = (b >= 8'h41 && b <= 8'h5a) ? b + 8'h20 : b;
      if (held_chars.size() < StoreDepth) held_chars.insert(held_chars.size(), lc);
      else dropped = 1;
      if (!is_last) return;
      buf_c = held_chars;
      n = buf_c.size();
      for (gap = n / 2; gap > 0; gap = gap / 2) begin
        for (i = gap; i < n; i++) begin
          tmp = buf_c[i];
          j = i;
          while (j >= gap && (buf_c[j-gap] ^ 8'h80) > (tmp ^ 8'h80)) begin
            buf_c[j] = buf_c[j-gap];
            j -= gap;
          end
          buf_c[j] = tmp;
        end
      end
      for (i = 0; i < n; i++) begin
        e.data  = buf_c[i];
        e.last  = (i == n - 1);
        e.trunc = dropped;
        sorted_q.insert(sorted_q.size(), e);
      end
      held_chars.delete();
      dropped = 0;
    endfunction

    task check_result(logic [7:0] d, logic l, logic t);
      sorted_char_t e;
      if (sorted_q.size() == 0) begin
        report($sformatf("unexpected byte %h", d));
        return;
      end
      e = sorted_q.pop_front();
      if (d !== e.data) report($sformatf("byte %h, want %h", d, e.data));
      if (l !== e.last) report($sformatf("last %b, want %b", l, e.last));
      if (t !== e.trunc) report($sformatf("truncated %b, want %b", t, e.trunc));
    endtask
  endclass

  logic       clk_i = 0;
  logic       rst_ni = 0;
  logic       s_tvalid_i = 0;
  logic       s_tready_o;
  logic [7:0] s_tdata_i = '0;
  logic       s_tlast_i = 0;
  logic       m_tvalid_o;
  logic       m_tready_i = 0;
  logic [7:0] m_tdata_o;
  logic       m_tlast_o;
  logic       m_tuser_o;

  sort_scoreboard sb = new();
  bit sink_hold;
  bit sink_stalled;
  int unsigned cycle_cnt;

  shell_sort_lowercase_chars_top dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sink: random stalls, plus a long hold-off when asked
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold) begin
        m_tready_i <= 0;
        repeat (400) @(negedge clk_i);
        sink_hold = 0;
      end
      w = sink_stalled ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        m_tready_i <= 0;
        repeat (w) @(negedge clk_i);
      end
      m_tready_i <= 1;
      @(posedge clk_i);
      while (!m_tvalid_o) @(posedge clk_i);
      sb.check_result(m_tdata_o, m_tlast_o, m_tuser_o);
    end
  end

  // called at a falling edge; valid stays up between back-to-back transactions
  task automatic send_char(input logic [7:0] b, input logic l, input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 4) : 0;
    if (w > 0) begin
      s_tvalid_i <= 0;
      repeat (w) @(negedge clk_i);
    end
    s_tvalid_i <= 1;
    s_tdata_i  <= b;
    s_tlast_i  <= l;
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    sb.note_input(b, l);
    @(negedge clk_i);
  endtask

  task automatic send_string(input int len, input bit gaps);
    for (int k = 0; k < len; k++) begin
      logic [7:0] b;
      case ($urandom_range(0, 3))
        0: b = 8'($urandom_range(8'h41, 8'h5a));
        1: b = 8'($urandom_range(8'h61, 8'h7a));
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_char(b, k == len - 1, gaps);
    end
  endtask

  task automatic drain();
    s_tvalid_i <= 0;
    while (sb.sorted_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int len;
    sb.dropped = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    // directed: single byte, letter edges, sign order, duplicates
    send_char(8'h41, 1, 1);
    send_char(8'h5a, 0, 1);
    send_char(8'h40, 0, 1);
    send_char(8'h5b, 0, 1);
    send_char(8'h00, 0, 1);
    send_char(8'hff, 0, 1);
    send_char(8'h80, 0, 1);
    send_char(8'h7f, 0, 1);
    send_char(8'h61, 0, 1);
    send_char(8'h61, 1, 1);
    drain();
    // overflow, dropped final byte
    send_string(StoreDepth + 3, 0);
    // exactly full
    send_string(StoreDepth, 1);
    drain();
    // long sink hold-off while the source keeps going
    sink_hold = 1;
    send_string(20, 0);
    send_string(10, 0);
    drain();
    for (int s = 0; s < 8; s++) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      sink_stalled = ($urandom_range(0, 5) == 0);
      send_string(len, $urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) drain();
    end
    sink_stalled = 0;
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0 && sb.sorted_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
